### design/fct_pkg.sv
// shared types and constants for the frustum cull engine
package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int ID_W       = 16;
    localparam int POS_W      = 24;
    localparam int EXT_W      = 23;
    localparam int NORM_W     = 12;
    localparam int OFS_W      = 28;
    localparam int CFG_W      = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_W      = 3;
    localparam int COORD_W    = POS_W + 1;
    localparam int PROD_W     = COORD_W + NORM_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_SH    = 10;

    // plane word layout
    localparam int NX_LSB  = 0;
    localparam int NY_LSB  = 12;
    localparam int NZ_LSB  = 24;
    localparam int OFS_LSB = 36;

    typedef enum logic [IDX_W-1:0] {
        REG_PLANE_LEFT   = 3'd0,
        REG_PLANE_RIGHT  = 3'd1,
        REG_PLANE_TOP    = 3'd2,
        REG_PLANE_BOTTOM = 3'd3,
        REG_PLANE_NEAR   = 3'd4,
        REG_PLANE_FAR    = 3'd5,
        REG_CULL_MODE    = 3'd6
    } reg_idx_t;

    typedef logic [CFG_W-1:0] plane_word_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [EXT_W-1:0]        half_x;
        logic [EXT_W-1:0]        half_y;
        logic [EXT_W-1:0]        half_z;
        logic [EXT_W-1:0]        radius;
        logic                    outside;
    } item_t;

endpackage

### design/fct_cfg.sv
// plane and mode registers behind the apb-style port
module fct_cfg
    import fct_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ADDR_W-1:0]               paddr,
    input  logic [CFG_W-1:0]                pwdata,
    output logic [CFG_W-1:0]                prdata,
    output logic                            pready,
    output logic [NUM_PLANES-1:0][CFG_W-1:0] planes,
    output logic                            sphere
);

    logic [NUM_PLANES-1:0][CFG_W-1:0] plane_reg;
    logic                             mode_reg;
    logic [IDX_W-1:0]                 idx;
    logic                             wr_en;

    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign planes = plane_reg;
    assign sphere = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (idx == IDX_W'(p))
                    plane_reg[p] <= pwdata;
            end
            if (idx == REG_CULL_MODE)
                mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            if (idx == IDX_W'(p))
                prdata = plane_reg[p];
        end
        if (idx == REG_CULL_MODE)
            prdata = {{(CFG_W-1){1'b0}}, mode_reg};
    end

endmodule

### design/fct_cell.sv
// one plane test cell: products stage, then sum and compare stage
module fct_cell
    import fct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  plane_word_t plane,
    input  logic        sphere,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        in_ready,
    output logic        out_valid,
    output item_t       out_item,
    input  logic        out_ready
);

    logic signed [NORM_W-1:0]  n [3];
    logic signed [POS_W-1:0]   pos [3];
    logic [EXT_W-1:0]          half [3];
    logic signed [COORD_W-1:0] coord [3];
    logic signed [OFS_W-1:0]   ofs;

    logic                      a_valid_reg;
    item_t                     a_item_reg;
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [PROD_W-1:0]  prod_next [3];
    logic                      b_valid_reg;
    item_t                     b_item_reg;
    item_t                     b_item_next;

    logic                      a_ready;
    logic                      b_ready;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   bound;

    assign n[0] = plane[NX_LSB +: NORM_W];
    assign n[1] = plane[NY_LSB +: NORM_W];
    assign n[2] = plane[NZ_LSB +: NORM_W];
    assign ofs  = plane[OFS_LSB +: OFS_W];

    assign pos[0]  = in_item.pos_x;
    assign pos[1]  = in_item.pos_y;
    assign pos[2]  = in_item.pos_z;
    assign half[0] = in_item.half_x;
    assign half[1] = in_item.half_y;
    assign half[2] = in_item.half_z;

    // box mode pushes the centre to the corner on the normal's side
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            coord[i] = {pos[i][POS_W-1], pos[i]};
            if (!sphere && n[i] != '0)
            begin
                if (n[i][NORM_W-1])
                    coord[i] = coord[i] - $signed({2'b00, half[i]});
                else
                    coord[i] = coord[i] + $signed({2'b00, half[i]});
            end
            prod_next[i] = coord[i] * n[i];
        end
    end

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg <= in_item;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= prod_next[i];
        end
        if (b_ready && a_valid_reg)
            b_item_reg <= b_item_next;
    end

    always_comb
    begin
        acc = {{(ACC_W-PROD_W){prod_reg[0][PROD_W-1]}}, prod_reg[0]}
            + {{(ACC_W-PROD_W){prod_reg[1][PROD_W-1]}}, prod_reg[1]}
            + {{(ACC_W-PROD_W){prod_reg[2][PROD_W-1]}}, prod_reg[2]}
            + {{(ACC_W-OFS_W-FRAC_SH){ofs[OFS_W-1]}}, ofs, {FRAC_SH{1'b0}}};
        if (sphere)
            bound = {{(ACC_W-EXT_W-FRAC_SH){1'b0}}, a_item_reg.radius, {FRAC_SH{1'b0}}};
        else
            bound = '0;
        b_item_next         = a_item_reg;
        b_item_next.outside = a_item_reg.outside || (acc > bound);
    end

endmodule

### design/frustum_cull_test.sv
// frustum cull engine top level: six plane cells in a chain and an output register
// an accepted entity passes all six cells, then the output register
// throughput: one entity per cycle unless stalled; two-stage cells, one per plane
// culled entities leave the chain at its end and produce no request
// reset clears all planes and cull_mode (box test), so every entity is visible
// reset also empties the cell chain and the output register
module frustum_cull_test
    import fct_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [CFG_W-1:0]        pwdata,
    output logic [CFG_W-1:0]        prdata,
    output logic                    pready,
    input  logic                    entity_valid,
    output logic                    entity_stall,
    input  logic [ID_W-1:0]         entity_id,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic [EXT_W-1:0]        half_x,
    input  logic [EXT_W-1:0]        half_y,
    input  logic [EXT_W-1:0]        half_z,
    input  logic [EXT_W-1:0]        sphere_radius,
    output logic                    visible_valid,
    input  logic                    visible_stall,
    output logic [ID_W-1:0]         visible_id
);

    logic [NUM_PLANES-1:0][CFG_W-1:0] planes;
    logic                             sphere;
    logic                             chain_valid [NUM_PLANES+1];
    item_t                            chain_item  [NUM_PLANES+1];
    logic                             chain_ready [NUM_PLANES+1];
    logic                             visible_valid_reg;
    logic [ID_W-1:0]                  visible_id_reg;
    logic                             slot_free;
    logic                             load;

    fct_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes),
        .sphere  (sphere)
    );

    always_comb
    begin
        chain_valid[0]        = entity_valid;
        chain_item[0].id      = entity_id;
        chain_item[0].pos_x   = pos_x;
        chain_item[0].pos_y   = pos_y;
        chain_item[0].pos_z   = pos_z;
        chain_item[0].half_x  = half_x;
        chain_item[0].half_y  = half_y;
        chain_item[0].half_z  = half_z;
        chain_item[0].radius  = sphere_radius;
        chain_item[0].outside = 1'b0;
    end

    assign entity_stall = !chain_ready[0];

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_cell
        fct_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (planes[p]),
            .sphere    (sphere),
            .in_valid  (chain_valid[p]),
            .in_item   (chain_item[p]),
            .in_ready  (chain_ready[p]),
            .out_valid (chain_valid[p+1]),
            .out_item  (chain_item[p+1]),
            .out_ready (chain_ready[p+1])
        );
    end

    // culled entities are dropped without waiting for the output slot
    assign slot_free = !visible_valid_reg || !visible_stall;
    assign chain_ready[NUM_PLANES] = chain_item[NUM_PLANES].outside || slot_free;
    assign load = chain_valid[NUM_PLANES] && !chain_item[NUM_PLANES].outside && slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            visible_valid_reg <= 1'b0;
        else if (slot_free)
            visible_valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            visible_id_reg <= chain_item[NUM_PLANES].id;
    end

    assign visible_valid = visible_valid_reg;
    assign visible_id    = visible_id_reg;

    a_first_cell_free: assert property (@(posedge clk) disable iff (!rst_n)
        !g_cell[0].u_cell.a_valid_reg |-> !entity_stall)
        else $error("entity stalled with an empty first cell");

    a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
        entity_valid && !entity_stall |=> g_cell[0].u_cell.a_valid_reg)
        else $error("accepted entity missing from first cell");

    a_output_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(visible_valid) |->
            $past(chain_valid[NUM_PLANES] && !chain_item[NUM_PLANES].outside))
        else $error("visible request without an inside entity at chain end");

endmodule
